// File: design/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Request and result payloads, action codes, character codes and the
// memory port bundle between the sequencer and the cell memory.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Action codes
	localparam logic [2:0] ACT_CHAR    = 3'd0;
	localparam logic [2:0] ACT_CLEAR   = 3'd1;
	localparam logic [2:0] ACT_SET_ROW = 3'd2;
	localparam logic [2:0] ACT_SET_COL = 3'd3;
	localparam logic [2:0] ACT_READ    = 3'd4;

	// Character codes
	localparam logic [7:0] CODE_LF    = 8'd10;
	localparam logic [7:0] CODE_CR    = 8'd13;
	localparam logic [7:0] CODE_SPACE = 8'd32;

	// Color after reset, and the cell every entry holds after reset
	localparam logic [7:0]  COLOR_RESET = 8'd7;
	localparam logic [15:0] CELL_RESET  = {COLOR_RESET, CODE_SPACE};

	// Internal widths, wide enough for the largest screen (132 x 60)
	localparam int ADDR_W = 13;
	localparam int ROW_W  = 6;
	localparam int COL_W  = 8;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  char_code;
		logic [7:0]  position;
		logic [10:0] cell_index;
	} req_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [7:0] cell_color;
		logic [4:0] cursor_row;
		logic [6:0] cursor_column;
		logic       scrolled;
	} rsp_t;

	// One write port and one read port of the cell memory
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [15:0]       wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage
`default_nettype wire

// File: design/tcw_cell_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_cell_mem: character cell memory
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module tcw_cell_mem
	import tcw_pkg::*;
#(
	parameter int DEPTH = 2000
) (
	input  wire logic        clk,
	input  wire mem_req_t    mem_req,
	output logic      [15:0] rdata
);

	localparam int AW = $clog2(DEPTH);

	logic [15:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (mem_req.re) begin
			rdata <= mem[mem_req.raddr[AW-1:0]];
		end
	end

endmodule
`default_nettype wire

// File: design/tcw_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_seq: console sequencer
// Holds the cursor, decodes requests and drives the cell memory: single
// cell writes and reads, the scroll copy walk, blanking and the reset fill.
// ----------------------------------------------------------------------------
module tcw_seq
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  text_color,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire req_t        req,
	input  wire logic        out_free,
	output logic             res_valid,
	output rsp_t             res,
	output mem_req_t         mem_req,
	input  wire logic [15:0] rdata
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'(CELLS - COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] CELL_COUNT = ADDR_W'(CELLS);
	localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0]  COL_LIMIT  = COL_W'(COLUMNS);
	localparam logic [7:0]        POS_ROWS   = 8'(ROWS);
	localparam logic [7:0]        POS_COLS   = 8'(COLUMNS);

	// States
	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCROLL = 3'd2;
	localparam logic [2:0] S_BLANK  = 3'd3;
	localparam logic [2:0] S_WRITE  = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic              scrolled_q;
	logic              pend_wr_q;
	logic              rd_flag_q;
	logic [7:0]        code_q;
	logic              cp_v_s1;
	logic [ADDR_W-1:0] cp_dst_s1;

	logic              accept;
	logic              is_print;
	logic              idx_ok;
	logic              copy_issue;
	logic [ADDR_W-1:0] cur_addr;

	assign req_ready  = (state_q == S_IDLE);
	assign accept     = req_valid && req_ready;
	assign is_print   = (req.char_code != CODE_LF) && (req.char_code != CODE_CR);
	assign idx_ok     = {2'b00, req.cell_index} < CELL_COUNT;
	assign copy_issue = (ptr_q < COPY_END);
	assign cur_addr   = ADDR_W'(row_q) * ROW_STRIDE + ADDR_W'(col_q);

	// memory port
	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_INIT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ptr_q;
				mem_req.wdata = CELL_RESET;
			end
			S_IDLE: begin
				if (accept && req.action == ACT_CHAR && is_print && col_q < COL_LIMIT) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = cur_addr;
					mem_req.wdata = {text_color, req.char_code};
				end
				if (accept && req.action == ACT_READ && idx_ok) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = {2'b00, req.cell_index};
				end
			end
			S_SCROLL: begin
				// read one row below, write the data read last cycle
				mem_req.re    = copy_issue;
				mem_req.raddr = ptr_q + ROW_STRIDE;
				mem_req.we    = cp_v_s1;
				mem_req.waddr = cp_dst_s1;
				mem_req.wdata = rdata;
			end
			S_BLANK: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ptr_q;
				mem_req.wdata = {text_color, CODE_SPACE};
			end
			S_WRITE: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = cur_addr;
				mem_req.wdata = {text_color, code_q};
			end
			default: begin
			end
		endcase
	end

	// control state and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			ptr_q      <= '0;
			row_q      <= '0;
			col_q      <= '0;
			scrolled_q <= 1'b0;
			pend_wr_q  <= 1'b0;
			rd_flag_q  <= 1'b0;
			cp_v_s1    <= 1'b0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_CELL) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						scrolled_q <= 1'b0;
						pend_wr_q  <= 1'b0;
						rd_flag_q  <= 1'b0;
						state_q    <= S_DONE;
						ptr_q      <= '0;
						unique case (req.action)
							ACT_CHAR: begin
								if (!is_print) begin
									col_q <= '0;
									if (req.char_code == CODE_LF) begin
										if (row_q < LAST_ROW) begin
											row_q <= row_q + 1'b1;
										end else begin
											scrolled_q <= 1'b1;
											state_q    <= S_SCROLL;
										end
									end
								end else if (col_q < COL_LIMIT) begin
									col_q <= col_q + 1'b1;
								end else begin
									// wrap: line feed first, then write at column zero
									col_q     <= '0;
									pend_wr_q <= 1'b1;
									if (row_q < LAST_ROW) begin
										row_q   <= row_q + 1'b1;
										state_q <= S_WRITE;
									end else begin
										scrolled_q <= 1'b1;
										state_q    <= S_SCROLL;
									end
								end
							end
							ACT_CLEAR: begin
								state_q <= S_BLANK;
							end
							ACT_SET_ROW: begin
								if (req.position < POS_ROWS) begin
									row_q <= req.position[ROW_W-1:0];
								end
							end
							ACT_SET_COL: begin
								if (req.position < POS_COLS) begin
									col_q <= req.position[COL_W-1:0];
								end
							end
							ACT_READ: begin
								rd_flag_q <= idx_ok;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCROLL: begin
					// copy walk, then drain the last write before blanking
					cp_v_s1 <= copy_issue;
					if (copy_issue) begin
						ptr_q <= ptr_q + 1'b1;
					end else if (!cp_v_s1) begin
						state_q <= S_BLANK;
					end
				end
				S_BLANK: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_CELL) begin
						state_q <= pend_wr_q ? S_WRITE : S_DONE;
					end
				end
				S_WRITE: begin
					col_q   <= col_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			code_q <= req.char_code;
		end
		cp_dst_s1 <= ptr_q;
	end

	// result
	assign res_valid = (state_q == S_DONE) && out_free;
	always_comb begin
		res               = '0;
		res.cell_char     = rd_flag_q ? rdata[7:0]  : 8'd0;
		res.cell_color    = rd_flag_q ? rdata[15:8] : 8'd0;
		res.cursor_row    = row_q[4:0];
		res.cursor_column = col_q[6:0];
		res.scrolled      = scrolled_q;
	end

endmodule
`default_nettype wire

// File: design/text_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer: text-mode character console
//
//   channel   signals                          payload
//   request   req_valid / req_ready            req (req_t)
//   result    rsp_valid / rsp_ready            rsp (rsp_t)
//   config    color_we                         color_wdata (text color)
//
// Cursor, read and plain character requests are accepted, then the result is
// loaded into the output register. A character that wraps adds a cell write.
// Clear walks the cell memory one cell a cycle. A scroll copies one cell a
// cycle through the memory read port, drains the last copy, then blanks the
// bottom row; a wrapped character that caused it is written after that.
// After reset a fill pass writes the blank cell to all ROWS*COLUMNS cells
// (2000 by default); req_ready stays low during it.
// A held result stalls the sequencer only when the next result is ready.
// ----------------------------------------------------------------------------
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire req_t       req,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output rsp_t            rsp,
	input  wire logic       color_we,
	input  wire logic [7:0] color_wdata
);

	logic [7:0]  color_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;
	logic        out_free;
	logic        res_valid;
	rsp_t        res;
	mem_req_t    mem_req;
	logic [15:0] rdata;

	// color register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= COLOR_RESET;
		end else if (color_we) begin
			color_q <= color_wdata;
		end
	end

	tcw_seq #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_color (color_q),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res        (res),
		.mem_req    (mem_req),
		.rdata      (rdata)
	);

	tcw_cell_mem #(
		.DEPTH (ROWS * COLUMNS)
	) u_mem (
		.clk     (clk),
		.mem_req (mem_req),
		.rdata   (rdata)
	);

	// output register
	assign out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// File: design/tcw_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks of the text console writer
// Watches the top level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module tcw_checker
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);

	localparam logic [4:0] LAST_ROW_OUT = 5'(ROWS - 1);
	localparam logic [6:0] COL_MAX_OUT  = 7'(COLUMNS);

	// a held result keeps its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// one request at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// a scroll leaves the cursor on the bottom row near column zero
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.scrolled |->
			rsp.cursor_row == LAST_ROW_OUT && rsp.cursor_column <= 7'd1)
		else $error("bad cursor after scroll");

	// cursor column never passes the line end
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && COLUMNS < 128 |-> rsp.cursor_column <= COL_MAX_OUT)
		else $error("cursor column out of range");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (.*);
`default_nettype wire

// File: verif/tcw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_tb_checker: screen model and result checker for the text console writer
// Watches the request, result and color ports, keeps its own copy of the
// screen, the cursor and the text color, predicts one result per accepted
// request and compares every accepted result field by field, in order.
// ----------------------------------------------------------------------------
module tcw_tb_checker
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_ready,
	input  req_t       req,
	input  logic       rsp_valid,
	input  logic       rsp_ready,
	input  rsp_t       rsp,
	input  logic       color_we,
	input  logic [7:0] color_wdata,
	output int         errors,
	output int         pending,
	output int         replies,
	output int         scrolls,
	output int         reads
);

	localparam int CELLS = COLUMNS * ROWS;

	// Shadow of the console: cells hold {color, code}
	logic [15:0] screen [CELLS];
	int          cur_row;
	int          cur_col;
	logic [7:0]  color;
	rsp_t        awaited_rsp [$];

	int mism_cnt;
	int reply_cnt;
	int scroll_cnt;
	int read_cnt;

	// Cursor to column zero of the next row; on the last row, shift the
	// screen up one row and blank the bottom one. Returns 1 on a scroll.
	function automatic bit line_feed();
		int i;
		cur_col = 0;
		if (cur_row + 1 < ROWS) begin
			cur_row++;
			return 1'b0;
		end
		for (i = 0; i + COLUMNS < CELLS; i++)
			screen[i] = screen[i + COLUMNS];
		for (i = CELLS - COLUMNS; i < CELLS; i++)
			screen[i] = {color, CODE_SPACE};
		return 1'b1;
	endfunction

	// Apply one request to the shadow screen and return the result it gives
	function automatic rsp_t predict_console(input req_t r);
		rsp_t o;
		bit   scr;
		int   i;
		o   = '0;
		scr = 1'b0;
		case (r.action)
			ACT_CHAR: begin
				if (r.char_code == CODE_LF)
					scr = line_feed();
				else if (r.char_code == CODE_CR)
					cur_col = 0;
				else begin
					// wrap happens lazily, when the next printable shows up
					if (cur_col >= COLUMNS)
						scr = line_feed();
					screen[cur_row * COLUMNS + cur_col] = {color, r.char_code};
					cur_col++;
				end
			end
			ACT_CLEAR: begin
				for (i = 0; i < CELLS; i++)
					screen[i] = {color, CODE_SPACE};
			end
			ACT_SET_ROW: begin
				if (r.position < ROWS)
					cur_row = r.position;
			end
			ACT_SET_COL: begin
				if (r.position < COLUMNS)
					cur_col = r.position;
			end
			ACT_READ: begin
				if (r.cell_index < CELLS) begin
					o.cell_char  = screen[int'(r.cell_index)][7:0];
					o.cell_color = screen[int'(r.cell_index)][15:8];
				end
			end
			default: ;
		endcase
		o.cursor_row    = cur_row[4:0];
		o.cursor_column = cur_col[6:0];
		o.scrolled      = scr;
		return o;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("result field %s: expected %0d, got %0d", name, want, got);
			mism_cnt++;
		end
	endfunction

	// Sample all ports at the clock edge; results are retired before the
	// request of the same edge is predicted
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		int   i;
		if (!arst_n) begin
			for (i = 0; i < CELLS; i++)
				screen[i] = CELL_RESET;
			cur_row    = 0;
			cur_col    = 0;
			color      = COLOR_RESET;
			awaited_rsp.delete();
			mism_cnt   = 0;
			reply_cnt  = 0;
			scroll_cnt = 0;
			read_cnt   = 0;
			errors     <= 0;
			pending    <= 0;
			replies    <= 0;
			scrolls    <= 0;
			reads      <= 0;
		end else begin
			if (color_we)
				color = color_wdata;

			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					$error("result accepted with no request outstanding");
					mism_cnt++;
				end else begin
					want = awaited_rsp.pop_front();
					check_field("cell_char", want.cell_char, rsp.cell_char);
					check_field("cell_color", want.cell_color, rsp.cell_color);
					check_field("cursor_row", want.cursor_row, rsp.cursor_row);
					check_field("cursor_column", want.cursor_column, rsp.cursor_column);
					check_field("scrolled", want.scrolled, rsp.scrolled);
					reply_cnt++;
					if (want.scrolled)
						scroll_cnt++;
				end
			end

			if (req_valid && req_ready) begin
				awaited_rsp.push_back(predict_console(req));
				if (req.action == ACT_READ)
					read_cnt++;
			end

			errors  <= mism_cnt;
			pending <= awaited_rsp.size();
			replies <= reply_cnt;
			scrolls <= scroll_cnt;
			reads   <= read_cnt;
		end
	end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the text console writer
// Directed requests for cursor limits, wrap, scroll, clear and reads, then
// weighted random requests over several phases with different text colors
// and different amounts of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
	import tcw_pkg::*;

	localparam int COLUMNS     = 80;
	localparam int ROWS        = 25;
	localparam int CELLS       = COLUMNS * ROWS;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 305;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       req_valid   = 1'b0;
	req_t       req         = '0;
	logic       rsp_ready   = 1'b0;
	logic       color_we    = 1'b0;
	logic [7:0] color_wdata = '0;
	logic       req_ready;
	logic       rsp_valid;
	rsp_t       rsp;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int sent           = 0;
	int errors;
	int pending;
	int replies;
	int scrolls;
	int reads;

	always #10 clk = ~clk;

	text_console_writer #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.color_we    (color_we),
		.color_wdata (color_wdata)
	);

	tcw_tb_checker #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_mon (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.color_we    (color_we),
		.color_wdata (color_wdata),
		.errors      (errors),
		.pending     (pending),
		.replies     (replies),
		.scrolls     (scrolls),
		.reads       (reads)
	);

	// Result back-pressure, redrawn every cycle
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic req_t make_req(input logic [2:0] act, input logic [7:0] code,
			input logic [7:0] pos, input logic [10:0] idx);
		req_t r;
		r.action     = act;
		r.char_code  = code;
		r.position   = pos;
		r.cell_index = idx;
		return r;
	endfunction

	// Weighted mix: mostly text, some line control, reads, cursor moves, clears and unused action codes
	function automatic req_t random_request();
		req_t r;
		int   pick;
		r = make_req(ACT_CHAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
			11'($urandom_range(2047)));
		pick = $urandom_range(99);
		if (pick < 55)
			r.action = ACT_CHAR;
		else if (pick < 60)
			r.char_code = CODE_LF;
		else if (pick < 62)
			r.char_code = CODE_CR;
		else if (pick < 63)
			r.action = ACT_CLEAR;
		else if (pick < 69) begin
			r.action = ACT_SET_ROW;
			if ($urandom_range(3) != 0)
				r.position = 8'($urandom_range(ROWS - 1));
		end else if (pick < 75) begin
			r.action = ACT_SET_COL;
			if ($urandom_range(3) != 0)
				r.position = 8'($urandom_range(COLUMNS - 1));
		end else if (pick < 95) begin
			r.action = ACT_READ;
			if ($urandom_range(7) != 0)
				r.cell_index = 11'($urandom_range(CELLS - 1));
		end else
			r.action = 3'($urandom_range(7, 5));
		return r;
	endfunction

	// Present one request and hold it until accepted; valid stays up across
	// back-to-back requests and drops only for an idle gap
	task automatic send_request(input req_t r);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sent++;
	endtask

	// Stop sending and wait for every outstanding result, then a short pause
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_color(input logic [7:0] c);
		color_wdata <= c;
		color_we    <= 1'b1;
		@(posedge clk);
		color_we    <= 1'b0;
	endtask

	// Reset contents, cursor limits, wrap, scroll, clear and unused actions
	task automatic run_directed();
		send_request(make_req(ACT_READ, 8'd0, 8'd0, 11'd0));
		send_request(make_req(ACT_READ, 8'd0, 8'd0, 11'd1999));
		send_request(make_req(ACT_READ, 8'd0, 8'd0, 11'd2000));
		send_request(make_req(ACT_READ, 8'd0, 8'd0, 11'd2047));
		send_request(make_req(ACT_CHAR, 8'd65, 8'd0, 11'd0));
		send_request(make_req(ACT_CHAR, 8'd0, 8'd255, 11'd2047));
		send_request(make_req(ACT_CHAR, 8'd255, 8'd0, 11'd0));
		send_request(make_req(ACT_CHAR, CODE_CR, 8'd0, 11'd0));
		send_request(make_req(ACT_READ, 8'd0, 8'd0, 11'd0));
		// last column, then wrap onto the next row
		send_request(make_req(ACT_SET_COL, 8'd0, 8'd79, 11'd0));
		send_request(make_req(ACT_CHAR, 8'd90, 8'd0, 11'd0));
		send_request(make_req(ACT_CHAR, 8'd87, 8'd0, 11'd0));
		// out-of-range cursor moves are dropped, the move to row 24 is taken
		send_request(make_req(ACT_SET_COL, 8'd0, 8'd80, 11'd0));
		send_request(make_req(ACT_SET_COL, 8'd0, 8'd255, 11'd0));
		send_request(make_req(ACT_SET_ROW, 8'd0, 8'd24, 11'd0));
		send_request(make_req(ACT_SET_ROW, 8'd0, 8'd25, 11'd0));
		send_request(make_req(ACT_SET_ROW, 8'd0, 8'd255, 11'd0));
		// line feed on the bottom row scrolls
		send_request(make_req(ACT_CHAR, CODE_LF, 8'd0, 11'd0));
		send_request(make_req(ACT_READ, 8'd0, 8'd0, 11'd0));
		// wrap on the bottom row scrolls too
		send_request(make_req(ACT_SET_COL, 8'd0, 8'd79, 11'd0));
		send_request(make_req(ACT_CHAR, 8'd81, 8'd0, 11'd0));
		send_request(make_req(ACT_CHAR, 8'd82, 8'd0, 11'd0));
		send_request(make_req(ACT_READ, 8'd0, 8'd0, 11'd1919));
		send_request(make_req(ACT_READ, 8'd0, 8'd0, 11'd1920));
		send_request(make_req(3'd5, 8'hAA, 8'h55, 11'h555));
		send_request(make_req(3'd6, 8'h55, 8'hAA, 11'h2AA));
		send_request(make_req(3'd7, 8'hFF, 8'hFF, 11'h7FF));
		send_request(make_req(ACT_CLEAR, 8'd0, 8'd0, 11'd0));
		send_request(make_req(ACT_READ, 8'd0, 8'd0, 11'd1920));
		send_request(make_req(ACT_SET_ROW, 8'd0, 8'd3, 11'd0));
		send_request(make_req(ACT_CHAR, CODE_LF, 8'd0, 11'd0));
	endtask

	// Main sequence
	initial begin
		int ph;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			// phase 0 keeps the reset color
			case (ph)
				0: ;
				1: write_color(8'hFF);
				2: write_color(8'h00);
				5: write_color(8'hF0);
				default: write_color(8'($urandom_range(255)));
			endcase
			if (ph == 0)
				run_directed();
			repeat (PHASE_ITEMS)
				send_request(random_request());
			drain();
		end

		$display("Sent %0d console requests over %0d phases and color settings;",
			sent, PHASES);
		$display("checked %0d results, including %0d scrolls and %0d cell reads.",
			replies, scrolls, reads);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog
	initial begin
		#(400_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
